>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the polar converter
// no dependencies; included by the files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define C2P_ASSERT_IMPL(name, clk_sig, rst_sig, pre, post, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define C2P_ASSERT_NEXT(name, clk_sig, rst_sig, pre, post, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/c2p_pkg.sv
// constants, tables and types of the cartesian to polar converter
// no dependencies; imported by every other file of the block except assert_macros.svh
package c2p_pkg;

    // field widths of the channels
    localparam int DELTA_W = 16;
    localparam int MAG_W   = 16;
    localparam int PHASE_W = 15;

    // bits of each delta field that are used and sign-extended (at most DELTA_W)
    localparam int IN_W            = 16;
    localparam int PHASE_FRAC_BITS = 6;

    // cordic formats: vectors scaled by 2^24, angles in degrees with 24 fraction bits
    localparam int ANG_FRAC     = 24;
    localparam int VEC_SHIFT    = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int VEC_W        = IN_W + VEC_SHIFT + 4;
    localparam int Z_W          = 32;
    localparam int ANG_W        = Z_W + 3;

    // square root datapath
    localparam int SQ_W       = 2 * IN_W;
    localparam int REM_W      = IN_W + 2;
    localparam int SQRT_STEPS = IN_W;

    // pipeline layout
    localparam int FRONT_STAGES = 3;
    localparam int MAP_STAGES   = 3;
    localparam int PIPE_DEPTH   = FRONT_STAGES + CORDIC_STEPS + MAP_STAGES;
    localparam int MAG_DELAY    = CORDIC_STEPS + MAP_STAGES - SQRT_STEPS - 1;

    // phase scaling
    localparam int PHASE_SHIFT = ANG_FRAC - PHASE_FRAC_BITS;
    localparam int P_W         = ANG_W - PHASE_SHIFT;

    localparam logic signed [Z_W-1:0]   ANG_RIGHT = Z_W'(64'sd90 << ANG_FRAC);
    localparam logic signed [ANG_W-1:0] ANG_HALF  = ANG_W'(64'sd180 << ANG_FRAC);
    localparam logic signed [ANG_W-1:0] ANG_FULL  = ANG_W'(64'sd360 << ANG_FRAC);
    localparam logic [ANG_W-1:0]        PHASE_HALF_LSB = ANG_W'(64'd1 << (PHASE_SHIFT - 1));
    localparam logic [P_W-1:0]          PHASE_TURN = P_W'(64'd360 << PHASE_FRAC_BITS);

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        754974720, 445687602, 235489089, 119537938, 60000930, 30029717,
        15018523, 7509719, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7
    };

    // octant information that rides alongside the cordic
    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } quad_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [PHASE_W-1:0] phase;
    } polar_t;

endpackage

>>> rtl/core/c2p_in_if.sv
// valid/ready channel carrying one cartesian motion vector per word
// depends on c2p_pkg for the field widths
interface c2p_in_if
    import c2p_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

>>> rtl/core/c2p_out_if.sv
// valid/ready channel carrying one polar result per word
// depends on c2p_pkg for the field widths
interface c2p_out_if
    import c2p_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   magnitude;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output magnitude, output phase, input ready);
    modport sink   (input valid, input magnitude, input phase, output ready);
endinterface

>>> rtl/core/cartesian_to_polar_converter.sv
// top level of the cartesian to polar converter: front, square root, cordic, output buffer
// depends on c2p_pkg, c2p_in_if, c2p_out_if, the c2p_* modules and assert_macros.svh
//
//   channel | dir | fields                          | word
//   cart    | in  | delta_x s16, delta_y s16        | motion vector, 6 fraction bits
//   polar   | out | magnitude u16, phase u15        | length, angle in 1/64 degree
//
// one word accepted per clock while the skid register is empty; a result passes through
// three front stages, the 28 cordic iterations, three angle-mapping stages
// and the output register
// reset clears only the stage valid bits and the output buffer; there is no clearing pass
// a stalled output fills the skid register, then ready drops and the pipeline freezes
// with its bubbles in place; nothing is dropped or repeated
`include "assert_macros.svh"

module cartesian_to_polar_converter
    import c2p_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    c2p_in_if.sink    cart,
    c2p_out_if.source polar
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [SQ_W-1:0]       sum_sq;
    logic [IN_W-1:0]       ax;
    logic [IN_W-1:0]       ay;
    quad_t                 quad;
    logic [IN_W-1:0]       mag;
    logic [PHASE_W-1:0]    phase;
    polar_t                word;
    logic                  push;

    assign cart.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], cart.valid};
        end
    end

    c2p_front u_front (
        .clk     (clk),
        .en      (en),
        .delta_x (cart.delta_x),
        .delta_y (cart.delta_y),
        .sum_sq  (sum_sq),
        .ax      (ax),
        .ay      (ay),
        .quad    (quad)
    );

    c2p_sqrt u_sqrt (
        .clk    (clk),
        .en     (en),
        .sum_sq (sum_sq),
        .mag    (mag)
    );

    c2p_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .ax    (ax),
        .ay    (ay),
        .quad  (quad),
        .phase (phase)
    );

    assign word.magnitude = MAG_W'(mag);
    assign word.phase     = phase;
    assign push           = en && vld_reg[PIPE_DEPTH-1];

    c2p_out_skid u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .word  (word),
        .room  (en),
        .polar (polar)
    );

    `C2P_ASSERT_NEXT(a_accept_enters, clk, rst_n, cart.valid && cart.ready, vld_reg[0], "accepted word lost at entry")
    `C2P_ASSERT_NEXT(a_drain_shows, clk, rst_n, push, polar.valid, "finished word not presented")
    `C2P_ASSERT_IMPL(a_phase_range, clk, rst_n, vld_reg[PIPE_DEPTH-1], P_W'(phase) < PHASE_TURN, "phase at or above a full turn")

endmodule

>>> rtl/core/c2p_front.sv
// front stages: absolute values and octant flags, squares, sum of squares
// depends on c2p_pkg
module c2p_front
    import c2p_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [DELTA_W-1:0] delta_x,
    input  logic signed [DELTA_W-1:0] delta_y,
    output logic [SQ_W-1:0]           sum_sq,
    output logic [IN_W-1:0]           ax,
    output logic [IN_W-1:0]           ay,
    output quad_t                     quad
);

    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    logic [IN_W-1:0]        abs_x;
    logic [IN_W-1:0]        abs_y;
    quad_t                  quad_next;

    logic [IN_W-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    quad_t           quad1_reg, quad2_reg, quad3_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sum_reg;

    assign sx = delta_x[IN_W-1:0];
    assign sy = delta_y[IN_W-1:0];

    // the most negative code maps onto 2^(IN_W-1), still in range unsigned
    assign abs_x = sx[IN_W-1] ? IN_W'(-sx) : IN_W'(sx);
    assign abs_y = sy[IN_W-1] ? IN_W'(-sy) : IN_W'(sy);

    // vertical axis is flipped: the angle's y is negative when delta_y is positive
    always_comb
    begin
        quad_next.x_neg   = sx[IN_W-1];
        quad_next.y_neg   = !sy[IN_W-1] && (sy != '0);
        quad_next.ax_zero = (sx == '0);
        quad_next.ay_zero = (sy == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= abs_x;
            ay1_reg   <= abs_y;
            quad1_reg <= quad_next;

            sqx_reg   <= SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
            sqy_reg   <= SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            quad2_reg <= quad1_reg;

            sum_reg   <= sqx_reg + sqy_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            quad3_reg <= quad2_reg;
        end
    end

    assign sum_sq = sum_reg;
    assign ax     = ax3_reg;
    assign ay     = ay3_reg;
    assign quad   = quad3_reg;

endmodule

>>> rtl/core/c2p_sqrt.sv
// pipelined digit-by-digit square root with round-half-up, one root bit per stage
// depends on c2p_pkg; output delayed to line up with the cordic phase
module c2p_sqrt
    import c2p_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] sum_sq,
    output logic [IN_W-1:0] mag
);

    logic [SQ_W-1:0]  rad_reg  [SQRT_STEPS];
    logic [IN_W-1:0]  root_reg [SQRT_STEPS];
    logic [REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [IN_W-1:0]  round_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        logic [SQ_W-1:0]  rad_in;
        logic [IN_W-1:0]  root_in;
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rad_in  = sum_sq;
            assign root_in = '0;
            assign rem_in  = '0;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
        end

        // remainder never exceeds twice the partial root, so its low bits suffice
        assign cur   = {rem_in[IN_W-1:0], rad_in[SQ_W-1 -: 2]};
        assign trial = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j] <= rad_in << 2;
                if (cur >= trial)
                begin
                    rem_reg[j]  <= cur - trial;
                    root_reg[j] <= {root_in[IN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= cur;
                    root_reg[j] <= {root_in[IN_W-2:0], 1'b0};
                end
            end
        end
    end

    // round up when the radicand lies above root^2 + root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            round_reg <= root_reg[SQRT_STEPS-1]
                       + IN_W'(rem_reg[SQRT_STEPS-1] > {2'b00, root_reg[SQRT_STEPS-1]});
        end
    end

    if (MAG_DELAY == 0)
    begin : g_nodly
        assign mag = round_reg;
    end
    else
    begin : g_dly
        logic [IN_W-1:0] dly_reg [MAG_DELAY];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dly_reg[0] <= round_reg;
                for (int k = 1; k < MAG_DELAY; k++)
                begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end

        assign mag = dly_reg[MAG_DELAY-1];
    end

endmodule

>>> rtl/core/c2p_cordic.sv
// unrolled vectoring cordic, one iteration per stage, then octant mapping and
// rounding of the angle to the phase scale; depends on c2p_pkg
module c2p_cordic
    import c2p_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [IN_W-1:0]    ax,
    input  logic [IN_W-1:0]    ay,
    input  quad_t              quad,
    output logic [PHASE_W-1:0] phase
);

    logic signed [VEC_W-1:0] u_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0] v_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]   z_reg [CORDIC_STEPS];
    quad_t                   q_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [VEC_W-1:0] u_in;
        logic signed [VEC_W-1:0] v_in;
        logic signed [Z_W-1:0]   z_in;
        quad_t                   q_in;

        if (i == 0)
        begin : g_first
            assign u_in = signed'(VEC_W'(ax) << VEC_SHIFT);
            assign v_in = signed'(VEC_W'(ay) << VEC_SHIFT);
            assign z_in = '0;
            assign q_in = quad;
        end
        else
        begin : g_rest
            assign u_in = u_reg[i-1];
            assign v_in = v_reg[i-1];
            assign z_in = z_reg[i-1];
            assign q_in = q_reg[i-1];
        end

        // arithmetic shifts round toward minus infinity
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!v_in[VEC_W-1])
                begin
                    u_reg[i] <= u_in + (v_in >>> i);
                    v_reg[i] <= v_in - (u_in >>> i);
                    z_reg[i] <= z_in + ATAN_TAB[i];
                end
                else
                begin
                    u_reg[i] <= u_in - (v_in >>> i);
                    v_reg[i] <= v_in + (u_in >>> i);
                    z_reg[i] <= z_in - ATAN_TAB[i];
                end
                q_reg[i] <= q_in;
            end
        end
    end

    quad_t                   q_fin;
    logic signed [Z_W-1:0]   z_sel;
    logic signed [ANG_W-1:0] z_ext;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [ANG_W-1:0] wrap_next;
    logic signed [ANG_W-1:0] wrap_reg;
    logic [ANG_W-1:0]        rnd;
    logic [P_W-1:0]          p_raw;
    logic [P_W-1:0]          p_next;
    logic [PHASE_W-1:0]      phase_reg;

    assign q_fin = q_reg[CORDIC_STEPS-1];

    // vectors on an axis take the exact angle, not the cordic's
    always_comb
    begin
        if (q_fin.ay_zero)
        begin
            z_sel = '0;
        end
        else if (q_fin.ax_zero)
        begin
            z_sel = ANG_RIGHT;
        end
        else
        begin
            z_sel = z_reg[CORDIC_STEPS-1];
        end
        z_ext = ANG_W'(z_sel);
    end

    always_comb
    begin
        if (!q_fin.x_neg)
        begin
            ang_next = q_fin.y_neg ? (ANG_FULL - z_ext) : z_ext;
        end
        else
        begin
            ang_next = q_fin.y_neg ? (ANG_HALF + z_ext) : (ANG_HALF - z_ext);
        end
    end

    always_comb
    begin
        if (ang_reg < 0)
        begin
            wrap_next = ang_reg + ANG_FULL;
        end
        else if (ang_reg >= ANG_FULL)
        begin
            wrap_next = ang_reg - ANG_FULL;
        end
        else
        begin
            wrap_next = ang_reg;
        end
    end

    // round half up to the phase scale; a full turn folds back to zero
    assign rnd   = ANG_W'(wrap_reg) + PHASE_HALF_LSB;
    assign p_raw = rnd[ANG_W-1:PHASE_SHIFT];

    always_comb
    begin
        if (p_raw >= PHASE_TURN)
        begin
            p_next = p_raw - PHASE_TURN;
        end
        else
        begin
            p_next = p_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg   <= ang_next;
            wrap_reg  <= wrap_next;
            phase_reg <= PHASE_W'(p_next);
        end
    end

    assign phase = phase_reg;

endmodule

>>> rtl/core/c2p_out_skid.sv
// two-word output buffer: output register plus skid register
// depends on c2p_pkg, c2p_out_if and assert_macros.svh
`include "assert_macros.svh"

module c2p_out_skid
    import c2p_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  polar_t    word,
    output logic      room,
    c2p_out_if.source polar
);

    polar_t out_reg;
    polar_t skid_reg;
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    logic   load_out_word, load_out_skid, load_skid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_word   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (out_valid_reg && !polar.ready)
        begin
            // output held: park an arriving word
            if (push)
            begin
                skid_valid_next = 1'b1;
                load_skid       = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            load_out_skid   = 1'b1;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            load_out_word  = 1'b1;
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_word)
        begin
            out_reg <= word;
        end
        else if (load_out_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= word;
        end
    end

    assign room            = !skid_valid_reg;
    assign polar.valid     = out_valid_reg;
    assign polar.magnitude = out_reg.magnitude;
    assign polar.phase     = out_reg.phase;

    `C2P_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid word without output word")
    `C2P_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, skid_valid_reg, !push, "word pushed into a full buffer")

endmodule

>>> dv/c2p_polar_checker.sv
`timescale 1ns / 1ps
// checker for the cartesian to polar converter: predicts every polar word from its cart word
// and compares in order; depends on c2p_pkg, c2p_in_if and c2p_out_if
module c2p_polar_checker
    import c2p_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    c2p_in_if    cart,
    c2p_out_if   polar,
    output int   mismatches,
    output int   outstanding
);

    // atan(2^-i) in degrees with 24 fraction bits
    localparam longint ARC_DEG [28] = '{
        754974720, 445687602, 235489089, 119537938, 60000930, 30029717,
        15018523, 7509719, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7
    };
    localparam int     ROTATIONS   = 28;
    localparam int     ANGLE_FRAC  = 24;
    localparam longint FULL_TURN   = longint'(360) << ANGLE_FRAC;
    localparam longint HALF_TURN   = longint'(180) << ANGLE_FRAC;
    localparam longint RIGHT_ANGLE = longint'(90) << ANGLE_FRAC;
    localparam longint unsigned PHASE_UNITS = longint'(360) << PHASE_FRAC_BITS;

    polar_t pending_q [$];
    polar_t want;
    int     fail_cnt = 0;

    // bitwise root with round half up
    function automatic longint unsigned rounded_root(longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = s;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        if (rem > root)
            root++;
        return root;
    endfunction

    // vectoring rotations on |x|, |y| scaled by 2^24; >>> on longint floors
    function automatic longint quadrant_angle(longint ax, longint ay);
        longint u;
        longint v;
        longint z;
        longint du;
        longint dv;
        if (ay == 0)
            return 0;
        if (ax == 0)
            return RIGHT_ANGLE;
        u = ax <<< 24;
        v = ay <<< 24;
        z = 0;
        for (int i = 0; i < ROTATIONS; i++)
        begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0)
            begin
                u = u + du;
                v = v - dv;
                z = z + ARC_DEG[i];
            end
            else
            begin
                u = u - du;
                v = v + dv;
                z = z - ARC_DEG[i];
            end
        end
        return z;
    endfunction

    function automatic polar_t predict_polar(logic [DELTA_W-1:0] dx_raw,
                                             logic [DELTA_W-1:0] dy_raw);
        longint          x;
        longint          y;
        longint          ax;
        longint          ay;
        longint          z;
        longint          a;
        longint unsigned p;
        longint unsigned root;
        polar_t          res;
        x  = longint'(signed'(dx_raw[IN_W-1:0]));
        // image rows grow downward, so the vertical axis flips
        y  = -longint'(signed'(dy_raw[IN_W-1:0]));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        root = rounded_root(longint'(ax * ax + ay * ay));
        p = 0;
        if (ax != 0 || ay != 0)
        begin
            z = quadrant_angle(ax, ay);
            if (x >= 0)
                a = (y >= 0) ? z : FULL_TURN - z;
            else
                a = (y >= 0) ? HALF_TURN - z : HALF_TURN + z;
            if (a < 0)
                a = a + FULL_TURN;
            if (a >= FULL_TURN)
                a = a - FULL_TURN;
            p = ((longint'(a) << PHASE_FRAC_BITS) + (64'd1 << (ANGLE_FRAC - 1))) >> ANGLE_FRAC;
            if (p >= PHASE_UNITS)
                p = p - PHASE_UNITS;
        end
        res.magnitude = root[MAG_W-1:0];
        res.phase     = p[PHASE_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_q.delete();
            mismatches  <= fail_cnt;
            outstanding <= 0;
        end
        else
        begin
            if (cart.valid && cart.ready)
                pending_q.push_back(predict_polar(cart.delta_x, cart.delta_y));
            if (polar.valid && polar.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: polar word with none expected: magnitude %0d phase %0d",
                             $time, polar.magnitude, polar.phase);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (polar.magnitude !== want.magnitude)
                    begin
                        fail_cnt++;
                        $display("%0t: magnitude mismatch: expected %0d actual %0d",
                                 $time, want.magnitude, polar.magnitude);
                    end
                    if (polar.phase !== want.phase)
                    begin
                        fail_cnt++;
                        $display("%0t: phase mismatch: expected %0d actual %0d",
                                 $time, want.phase, polar.phase);
                    end
                end
            end
            mismatches  <= fail_cnt;
            outstanding <= pending_q.size();
        end
    end

endmodule

>>> dv/tb_cartesian_to_polar_converter.sv
`timescale 1ns / 1ps
// testbench top for the cartesian to polar converter: clock, reset, stimulus, flow control
// and the verdict; depends on c2p_pkg, the channel interfaces, the rtl and c2p_polar_checker
module tb_cartesian_to_polar_converter;
    import c2p_pkg::*;

    localparam int RANDOM_WORDS   = 1400;
    localparam int CALM_TAIL      = 200;
    localparam int STALL_AT       = 400;
    localparam int STALL_LEN      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    // {delta_x, delta_y}
    localparam int DIRECTED_WORDS = 22;
    localparam logic [2*DELTA_W-1:0] DIRECTED [DIRECTED_WORDS] = '{
        {16'h0000, 16'h0000},   // zero vector
        {16'h7fff, 16'h0000},   // axes at both extremes
        {16'h8000, 16'h0000},
        {16'h0000, 16'h7fff},
        {16'h0000, 16'h8000},
        {16'h0001, 16'h0000},
        {16'h0000, 16'h0001},
        {16'h7fff, 16'h7fff},   // corners
        {16'h8000, 16'h8000},
        {16'h7fff, 16'h8000},
        {16'h8000, 16'h7fff},
        {16'h0001, 16'h0001},   // smallest diagonals
        {16'hffff, 16'hffff},
        {16'h0001, 16'hffff},
        {16'hffff, 16'h0001},
        {16'h7fff, 16'h0001},   // phase rounds up to a full turn and wraps
        {16'h8000, 16'hffff},
        {16'h0040, 16'h0040},
        {16'h5555, 16'haaaa},
        {16'haaaa, 16'h5555},
        {16'h0003, 16'hfffc},
        {16'h8001, 16'h8000}
    };

    localparam logic [DELTA_W-1:0] EDGE_VALS [6] = '{
        16'h8000, 16'h8001, 16'hffff, 16'h0000, 16'h0001, 16'h7fff
    };

    typedef enum {VEC_FULL, VEC_TINY, VEC_AXIS, VEC_DIAG, VEC_EDGE} vec_kind_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sent_words  = 0;
    int   total_words = DIRECTED_WORDS + RANDOM_WORDS;
    int   idle_cycles = 0;
    bit   stall_done  = 1'b0;

    c2p_in_if  cart();
    c2p_out_if polar();

    cartesian_to_polar_converter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cart  (cart),
        .polar (polar)
    );

    c2p_polar_checker polar_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cart        (cart),
        .polar       (polar),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // stretches without idling on either side, and none at all near the end
    function automatic bit calm_stretch(int n);
        return (n >= total_words - CALM_TAIL) || ((n / 250) % 4 == 3);
    endfunction

    task automatic send_vector(logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy);
        if (!calm_stretch(sent_words) && $urandom_range(0, 7) == 0)
        begin
            cart.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cart.valid   <= 1'b1;
        cart.delta_x <= dx;
        cart.delta_y <= dy;
        do
            @(posedge clk);
        while (!cart.ready);
        sent_words++;
    endtask

    initial
    begin
        int              r;
        vec_kind_t       kind;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        rst_n        = 1'b0;
        cart.valid   = 1'b0;
        cart.delta_x = '0;
        cart.delta_y = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_WORDS; i++)
            send_vector(DIRECTED[i][2*DELTA_W-1:DELTA_W], DIRECTED[i][DELTA_W-1:0]);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            r = $urandom_range(0, 19);
            kind = (r < 12) ? VEC_FULL : (r < 15) ? VEC_TINY : (r < 17) ? VEC_AXIS :
                   (r < 19) ? VEC_DIAG : VEC_EDGE;
            dx = DELTA_W'($urandom());
            dy = DELTA_W'($urandom());
            case (kind)
                VEC_TINY:
                begin
                    dx = DELTA_W'($urandom_range(0, 16)) - DELTA_W'(8);
                    dy = DELTA_W'($urandom_range(0, 16)) - DELTA_W'(8);
                end
                VEC_AXIS:
                begin
                    if ($urandom_range(0, 1))
                        dx = '0;
                    else
                        dy = '0;
                end
                VEC_DIAG:
                    dy = $urandom_range(0, 1) ? dx : -dx;
                VEC_EDGE:
                begin
                    dx = EDGE_VALS[$urandom_range(0, 5)];
                    dy = EDGE_VALS[$urandom_range(0, 5)];
                end
                default: ;
            endcase
            send_vector(dx, dy);
        end
        cart.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: short random stalls plus one long hold so the pipeline backs up
    initial
    begin
        int hold;
        hold        = 0;
        polar.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_done && sent_words >= STALL_AT)
            begin
                stall_done = 1'b1;
                hold       = STALL_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                polar.ready <= 1'b0;
            end
            else if (!calm_stretch(sent_words) && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 6) - 1;
                polar.ready <= 1'b0;
            end
            else
                polar.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cart.valid && cart.ready) || (polar.valid && polar.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> cartesian_to_polar_converter.f
+incdir+rtl/core
rtl/core/c2p_pkg.sv
rtl/core/c2p_in_if.sv
rtl/core/c2p_out_if.sv
rtl/core/c2p_front.sv
rtl/core/c2p_sqrt.sv
rtl/core/c2p_cordic.sv
rtl/core/c2p_out_skid.sv
rtl/core/cartesian_to_polar_converter.sv
dv/c2p_polar_checker.sv
dv/tb_cartesian_to_polar_converter.sv
